>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cmdp_pkg.sv
// ----------------------------------------------------------------------------
// cmdp_pkg
// Types, constants and tables shared by the density plotter modules.
// ----------------------------------------------------------------------------
package cmdp_pkg;

    localparam int GRID       = 256;
    localparam int GRID_LOG2  = 8;
    localparam int COUNT_BITS = 20;
    localparam int POS_W      = GRID_LOG2 + 16;
    localparam int ADDR_W     = 2 * GRID_LOG2;
    localparam int COEF_W     = 23;
    localparam int OPND_W     = COEF_W + 1;
    localparam int CW         = 20;
    localparam int ANG_W      = 21;
    localparam int E_W        = $clog2(COUNT_BITS);
    localparam int LOG_W      = E_W + 8;

    localparam logic [1:0] OP_RUN   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_COEF_A     = 2'd0;
    localparam logic [1:0] REG_COEF_B     = 2'd1;
    localparam logic [1:0] REG_HIT_WEIGHT = 2'd2;
    localparam logic [1:0] REG_RUN_LENGTH = 2'd3;

    localparam logic signed [ANG_W-1:0] PI_Q      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 21'sd102944;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 21'sd411775;
    localparam logic signed [CW-1:0]    GAIN_Q    = 20'sd39797;
    localparam logic signed [15:0]      FIFTH_Q   = 16'sd13107;
    localparam longint                  RECIP_2PI = (64'd1 << 32) / 64'd411775;

    localparam logic [POS_W-1:0] POS_CENTER = POS_W'(GRID) << 15;

    typedef logic signed [CW-1:0] trig_t;

    typedef struct packed {
        logic [7:0] shade;
        logic       painted;
        logic       ratio_error;
    } shade_res_t;

    function automatic logic [15:0] atan_q(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/cmdp_if.sv
// ----------------------------------------------------------------------------
// cmdp_if
// Request and result channels of the density plotter.
// ----------------------------------------------------------------------------
interface cmdp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] cell_row;
    logic [7:0] cell_col;

    modport source (output valid, opcode, cell_row, cell_col, input ready);
    modport sink   (input valid, opcode, cell_row, cell_col, output ready);
endinterface

interface cmdp_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] pos_x_out;
    logic [23:0] pos_y_out;
    logic [19:0] peak_out;
    logic [7:0]  shade;
    logic        painted;
    logic        ratio_error;

    modport source (output valid, pos_x_out, pos_y_out, peak_out, shade, painted,
                    ratio_error, input ready);
    modport sink   (input valid, pos_x_out, pos_y_out, peak_out, shade, painted,
                    ratio_error, output ready);
endinterface

>>> hw/rtl/cmdp_cordic.sv
// ----------------------------------------------------------------------------
// cmdp_cordic
// Angle = coef*pos, range reduction, then 16-step rotation CORDIC (sin, cos).
// ----------------------------------------------------------------------------
module cmdp_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [cmdp_pkg::OPND_W-1:0]  coef,
    input  logic [cmdp_pkg::POS_W-1:0]          pos,
    output logic                                done,
    output cmdp_pkg::trig_t                     sin_q,
    output cmdp_pkg::trig_t                     cos_q
);
    import cmdp_pkg::*;

    localparam int PROD_W = OPND_W + POS_W + 1;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_ANG  = 3'd1;
    localparam logic [2:0] C_REM  = 3'd2;
    localparam logic [2:0] C_FOLD = 3'd3;
    localparam logic [2:0] C_ITER = 3'd4;

    logic [2:0]               state_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [23:0]              mag_reg;
    logic                     sign_reg;
    logic [37:0]              qprod_reg;
    logic signed [ANG_W-1:0]  r_reg;
    logic                     flip_reg;
    trig_t                    x_reg, y_reg, z_reg;
    logic [3:0]               step_reg;
    logic                     done_reg;

    logic signed [PROD_W-1:0]    ang_full;
    logic signed [PROD_W-24:0]   ang;
    logic [23:0]                 mag;
    logic [5:0]                  q;
    logic [24:0]                 rm0, rm;
    logic signed [ANG_W-1:0]     r_pos, r_next;
    logic signed [ANG_W-1:0]     r1, r2;
    logic                        flip_next;
    trig_t                       dx, dy, at;

    always_comb
    begin
        ang_full = prod_reg + PROD_W'(64'd1 << 22);
        ang      = ang_full[PROD_W-1:23];
        mag      = ang[PROD_W-24] ? 24'(-ang) : 24'(ang);

        // quotient estimate is low by at most one
        q      = qprod_reg[37:32];
        rm0    = {1'b0, mag_reg} - 25'(25'(q) * 25'(TWO_PI_Q));
        rm     = (rm0 >= 25'(TWO_PI_Q)) ? rm0 - 25'(TWO_PI_Q) : rm0;
        r_pos  = $signed({2'b00, rm[18:0]});
        r_next = sign_reg ? -r_pos : r_pos;

        if (r_reg > PI_Q)
            r1 = r_reg - TWO_PI_Q;
        else if (r_reg < -PI_Q)
            r1 = r_reg + TWO_PI_Q;
        else
            r1 = r_reg;
        flip_next = 1'b0;
        r2        = r1;
        if (r1 > HALF_PI_Q)
        begin
            r2        = PI_Q - r1;
            flip_next = 1'b1;
        end
        else if (r1 < -HALF_PI_Q)
        begin
            r2        = -PI_Q - r1;
            flip_next = 1'b1;
        end

        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = $signed({4'b0000, atan_q(step_reg)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == C_ITER) && (step_reg == 4'd15);
            unique case (state_reg)
                C_IDLE: if (start) state_reg <= C_ANG;
                C_ANG:  state_reg <= C_REM;
                C_REM:  state_reg <= C_FOLD;
                C_FOLD: state_reg <= C_ITER;
                C_ITER:
                begin
                    if (step_reg == 4'd15)
                        state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE: prod_reg <= PROD_W'(coef) * $signed({1'b0, pos});
            C_ANG:
            begin
                mag_reg   <= mag;
                sign_reg  <= ang[PROD_W-24];
                qprod_reg <= 38'(mag) * 38'(RECIP_2PI);
            end
            C_REM:  r_reg <= r_next;
            C_FOLD:
            begin
                z_reg    <= r2[CW-1:0];
                flip_reg <= flip_next;
                x_reg    <= GAIN_Q;
                y_reg    <= '0;
                step_reg <= 4'd0;
            end
            C_ITER:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                step_reg <= step_reg + 4'd1;
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign sin_q = y_reg;
    assign cos_q = flip_reg ? -x_reg : x_reg;

endmodule

>>> hw/rtl/cmdp_shade.sv
// ----------------------------------------------------------------------------
// cmdp_shade
// log2 of peak and count by repeated squaring, then a bit-serial divide.
// ----------------------------------------------------------------------------
module cmdp_shade (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cmdp_pkg::COUNT_BITS-1:0]   cnt,
    input  logic [cmdp_pkg::COUNT_BITS-1:0]   peak,
    output logic                              done,
    output cmdp_pkg::shade_res_t              res
);
    import cmdp_pkg::*;

    localparam int NUM_W = LOG_W + 9;
    localparam int DC_W  = $clog2(NUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            state_reg;
    logic                  pass_reg;
    logic [COUNT_BITS-1:0] cnt_reg, peak_reg;
    logic [E_W-1:0]        e_reg;
    logic [30:0]           m_reg;
    logic [7:0]            frac_reg;
    logic [2:0]            bit_reg;
    logic [LOG_W-1:0]      lp_reg;
    logic                  err_reg;
    logic [NUM_W-1:0]      num_reg, quo_reg;
    logic [LOG_W-1:0]      rem_reg;
    logic [DC_W-1:0]       dcnt_reg;
    shade_res_t            res_reg;
    logic                  done_reg;

    logic [COUNT_BITS-1:0] v;
    logic [E_W-1:0]        e;
    logic [61:0]           sq;
    logic [31:0]           t;
    logic [7:0]            frac_next;
    logic [LOG_W-1:0]      log_val;
    logic [LOG_W:0]        rem_sh;
    logic                  qbit;
    logic [NUM_W-1:0]      val;
    logic [7:0]            shade_v;

    always_comb
    begin
        v = pass_reg ? cnt_reg : peak_reg;
        e = '0;
        for (int i = 0; i < COUNT_BITS; i++)
            if (v[i]) e = E_W'(i);

        sq        = 62'(m_reg) * 62'(m_reg);
        t         = sq[61:30];
        frac_next = frac_reg;
        if (t[31]) frac_next[bit_reg] = 1'b1;
        log_val   = {e_reg, frac_next};

        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        qbit   = (rem_sh >= (LOG_W+1)'(lp_reg));

        val = NUM_W'(300) - quo_reg;
        if (quo_reg >= NUM_W'(300))
            shade_v = 8'd0;
        else
            shade_v = (val > NUM_W'(255)) ? 8'd255 : val[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE: if (start) state_reg <= S_NORM;
                S_NORM: state_reg <= S_SQ;
                S_SQ:
                begin
                    if (bit_reg == 3'd0)
                    begin
                        if (!pass_reg)
                            state_reg <= S_NORM;
                        else if (lp_reg == '0)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_DIV: if (dcnt_reg == DC_W'(NUM_W-1)) state_reg <= S_OUT;
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg  <= cnt;
                peak_reg <= (peak == '0) ? COUNT_BITS'(1) : peak;
                pass_reg <= 1'b0;
            end
            S_NORM:
            begin
                e_reg    <= e;
                m_reg    <= 31'(v) << (5'd30 - 5'(e));
                frac_reg <= '0;
                bit_reg  <= 3'd7;
            end
            S_SQ:
            begin
                m_reg    <= t[31] ? t[31:1] : t[30:0];
                frac_reg <= frac_next;
                bit_reg  <= bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    if (!pass_reg)
                    begin
                        lp_reg   <= log_val;
                        pass_reg <= 1'b1;
                    end
                    else
                    begin
                        err_reg  <= (lp_reg == '0);
                        num_reg  <= NUM_W'(log_val) * NUM_W'(255) + NUM_W'(lp_reg)
                                    - NUM_W'(1);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        dcnt_reg <= '0;
                    end
                end
            end
            S_DIV:
            begin
                rem_reg  <= qbit ? LOG_W'(rem_sh - (LOG_W+1)'(lp_reg)) : rem_sh[LOG_W-1:0];
                quo_reg  <= {quo_reg[NUM_W-2:0], qbit};
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg + DC_W'(1);
            end
            S_OUT:
            begin
                res_reg.painted     <= 1'b1;
                res_reg.ratio_error <= err_reg;
                res_reg.shade       <= err_reg ? 8'd0 : shade_v;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> hw/rtl/chaotic_map_density_plotter_unit.sv
// ----------------------------------------------------------------------------
// chaotic_map_density_plotter_unit
// De Jong attractor iterator with a 256x256 saturating density store.
// ----------------------------------------------------------------------------
// One request at a time; one result per request. A run performs run_length
// iterations, each with four sine/cosine evaluations on one shared
// 16-step CORDIC, then a read-modify-write of the density store. A read
// of a nonzero cell runs two log2 passes and, unless the peak's log2 is
// zero, a serial divide. A clear sweeps all 65536 cells of the store one
// cell per cycle; the same sweep runs after reset before the first request
// is taken. Configuration writes are taken at any time.
module chaotic_map_density_plotter_unit (
    input  logic        clk,
    input  logic        rst_n,
    cmdp_cmd_if.sink    cmd,
    cmdp_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cmdp_pkg::*;

    localparam int MP_W = CW + 16;
    localparam int T_W  = MP_W + GRID_LOG2 + 1;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CSTART = 4'd2;
    localparam logic [3:0] ST_CWAIT  = 4'd3;
    localparam logic [3:0] ST_MAP    = 4'd4;
    localparam logic [3:0] ST_CELL   = 4'd5;
    localparam logic [3:0] ST_RDCELL = 4'd6;
    localparam logic [3:0] ST_UPD    = 4'd7;
    localparam logic [3:0] ST_RDADDR = 4'd8;
    localparam logic [3:0] ST_RDDATA = 4'd9;
    localparam logic [3:0] ST_SHADE  = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;

    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg;
    logic [7:0]               hit_weight_reg;
    logic [15:0]              run_length_reg;

    logic [3:0]            state_reg;
    logic [POS_W-1:0]      pos_x_reg, pos_y_reg, nx_reg, ny_reg;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [ADDR_W-1:0]     clr_addr_reg, addr_reg;
    logic                  clr_rep_reg;
    logic [15:0]           rem_reg;
    logic [1:0]            k_reg;
    trig_t                 s_reg, dx_reg, dy_reg;
    logic signed [MP_W-1:0] px_reg, py_reg;
    logic [7:0]            row_reg, col_reg;
    shade_res_t            rd_res_reg;
    logic                  res_valid_reg;
    logic [23:0]           out_x_reg, out_y_reg;
    logic [19:0]           out_peak_reg;
    shade_res_t            out_res_reg;

    logic [COUNT_BITS-1:0] mem [0:(1 << ADDR_W)-1];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic                      cfg_wr, accept, out_free;
    logic signed [OPND_W-1:0]  c_coef;
    logic [POS_W-1:0]          c_pos;
    logic                      c_start, c_done;
    trig_t                     c_sin, c_cos;
    logic                      sh_start, sh_done;
    shade_res_t                sh_res;
    logic [POS_W-1:0]          nx, ny;
    logic [COUNT_BITS:0]       sum;
    logic [COUNT_BITS-1:0]     cnt_next;

    function automatic logic [POS_W-1:0] map_pos(input logic signed [MP_W-1:0] p);
        logic signed [T_W-1:0]    w;
        logic signed [T_W-17:0]   s;
        logic signed [T_W-16:0]   v;
        logic [POS_W-1:0]         r;
        w = (T_W'(p) <<< GRID_LOG2) + T_W'(32768);
        s = w[T_W-1:16];
        v = (T_W-15)'(s) + $signed((T_W-15)'(POS_CENTER));
        if (v < 0)
            r = '0;
        else if (v > $signed((T_W-15)'({POS_W{1'b1}})))
            r = '1;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [GRID_LOG2-1:0] cell_of(input logic [POS_W-1:0] p);
        logic [POS_W:0] s;
        s = {1'b0, p} + (POS_W+1)'(32768);
        return s[POS_W] ? {GRID_LOG2{1'b1}} : s[POS_W-1:16];
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COEF_A:     prdata = 32'({1'b0, coef_a_reg} & 24'h7FFFFF);
            REG_COEF_B:     prdata = 32'({1'b0, coef_b_reg} & 24'h7FFFFF);
            REG_HIT_WEIGHT: prdata = 32'(hit_weight_reg);
            default:        prdata = 32'(run_length_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg     <= -23'sd167772;
            coef_b_reg     <= 23'sd83886;
            hit_weight_reg <= 8'd2;
            run_length_reg <= 16'd8000;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_COEF_A:     coef_a_reg     <= pwdata[COEF_W-1:0];
                REG_COEF_B:     coef_b_reg     <= pwdata[COEF_W-1:0];
                REG_HIT_WEIGHT: hit_weight_reg <= pwdata[7:0];
                default:        run_length_reg <= pwdata[15:0];
            endcase
        end
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res.ready;

    // CORDIC operand select: sin(a*y), cos(b*x), sin(-a*x), cos(-b*y)
    always_comb
    begin
        case (k_reg)
            2'd0:    begin c_coef = OPND_W'(coef_a_reg);  c_pos = pos_y_reg; end
            2'd1:    begin c_coef = OPND_W'(coef_b_reg);  c_pos = pos_x_reg; end
            2'd2:    begin c_coef = -OPND_W'(coef_a_reg); c_pos = pos_x_reg; end
            default: begin c_coef = -OPND_W'(coef_b_reg); c_pos = pos_y_reg; end
        endcase
        c_start  = (state_reg == ST_CSTART);
        sh_start = (state_reg == ST_RDDATA) && (rdata_reg != '0);

        nx = map_pos(px_reg);
        ny = map_pos(py_reg);

        sum      = {1'b0, rdata_reg} + (COUNT_BITS+1)'(hit_weight_reg);
        cnt_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

        mem_raddr = (state_reg == ST_RDADDR) ? {row_reg, col_reg} : addr_reg;
        mem_we    = (state_reg == ST_CLR) || (state_reg == ST_UPD);
        mem_waddr = (state_reg == ST_CLR) ? clr_addr_reg : addr_reg;
        mem_wdata = (state_reg == ST_CLR) ? '0 : cnt_next;
    end

    cmdp_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .coef  (c_coef),
        .pos   (c_pos),
        .done  (c_done),
        .sin_q (c_sin),
        .cos_q (c_cos)
    );

    cmdp_shade u_shade (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sh_start),
        .cnt   (rdata_reg),
        .peak  (peak_reg),
        .done  (sh_done),
        .res   (sh_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_addr_reg  <= '0;
            clr_rep_reg   <= 1'b0;
            pos_x_reg     <= POS_CENTER;
            pos_y_reg     <= POS_CENTER;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_FIN) && out_free)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (&clr_addr_reg)
                        state_reg <= clr_rep_reg ? ST_FIN : ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.opcode)
                            OP_RUN:
                                state_reg <= (run_length_reg == '0) ? ST_FIN : ST_CSTART;
                            OP_READ:  state_reg <= ST_RDADDR;
                            OP_CLEAR:
                            begin
                                state_reg    <= ST_CLR;
                                clr_addr_reg <= '0;
                                clr_rep_reg  <= 1'b1;
                                peak_reg     <= '0;
                                pos_x_reg    <= POS_CENTER;
                                pos_y_reg    <= POS_CENTER;
                            end
                            default:  state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_CSTART: state_reg <= ST_CWAIT;
                ST_CWAIT:
                begin
                    if (c_done)
                        state_reg <= (k_reg == 2'd3) ? ST_MAP : ST_CSTART;
                end
                ST_MAP:    state_reg <= ST_CELL;
                ST_CELL:   state_reg <= ST_RDCELL;
                ST_RDCELL: state_reg <= ST_UPD;
                ST_UPD:
                begin
                    pos_x_reg <= nx_reg;
                    pos_y_reg <= ny_reg;
                    if (cnt_next > peak_reg)
                        peak_reg <= cnt_next;
                    state_reg <= (rem_reg == 16'd1) ? ST_FIN : ST_CSTART;
                end
                ST_RDADDR: state_reg <= ST_RDDATA;
                ST_RDDATA: state_reg <= (rdata_reg == '0) ? ST_FIN : ST_SHADE;
                ST_SHADE:  if (sh_done) state_reg <= ST_FIN;
                ST_FIN:    if (out_free) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                row_reg    <= cmd.cell_row;
                col_reg    <= cmd.cell_col;
                rd_res_reg <= '0;
                rem_reg    <= run_length_reg;
                k_reg      <= 2'd0;
            end
            ST_CWAIT:
            begin
                if (c_done)
                begin
                    case (k_reg)
                        2'd0:    s_reg  <= c_sin;
                        2'd1:    dx_reg <= s_reg - c_cos;
                        2'd2:    s_reg  <= c_sin;
                        default: dy_reg <= s_reg - c_cos;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end
            end
            ST_MAP:
            begin
                px_reg <= MP_W'(dx_reg) * MP_W'(FIFTH_Q);
                py_reg <= MP_W'(dy_reg) * MP_W'(FIFTH_Q);
            end
            ST_CELL:
            begin
                nx_reg   <= nx;
                ny_reg   <= ny;
                addr_reg <= {cell_of(nx), cell_of(ny)};
            end
            ST_UPD:
            begin
                rem_reg <= rem_reg - 16'd1;
                k_reg   <= 2'd0;
            end
            ST_SHADE: if (sh_done) rd_res_reg <= sh_res;
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_x_reg    <= 24'(pos_x_reg);
                    out_y_reg    <= 24'(pos_y_reg);
                    out_peak_reg <= 20'(peak_reg);
                    out_res_reg  <= rd_res_reg;
                end
            end
            default: ;
        endcase
    end

    assign res.valid       = res_valid_reg;
    assign res.pos_x_out   = out_x_reg;
    assign res.pos_y_out   = out_y_reg;
    assign res.peak_out    = out_peak_reg;
    assign res.shade       = out_res_reg.shade;
    assign res.painted     = out_res_reg.painted;
    assign res.ratio_error = out_res_reg.ratio_error;

endmodule

>>> hw/rtl/cmdp_checker.sv
// ----------------------------------------------------------------------------
// cmdp_checker
// Port-level checks on the density plotter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmdp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] shade,
    input logic       painted,
    input logic       ratio_error
);

    // one request in flight: ready drops right after a request
    `CHK_NXT(a_one_req, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready held after request")

    `CHK_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped")

    `CHK_IMP(a_err_paint, clk, rst_n, res_valid && ratio_error, painted && shade == 8'd0, "bad error result")

    `CHK_IMP(a_unpainted, clk, rst_n, res_valid && !painted, shade == 8'd0 && !ratio_error, "unpainted shade")

endmodule

bind chaotic_map_density_plotter_unit cmdp_checker u_cmdp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .shade       (res.shade),
    .painted     (res.painted),
    .ratio_error (res.ratio_error)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the density plotter: drives run, read, clear and
// unused-opcode requests, reprograms the map registers between phases, and
// compares every result against a bit-accurate model of the map, the
// density store, the peak and the shade computation.
// ----------------------------------------------------------------------------
import cmdp_pkg::*;

typedef struct packed {
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [19:0] peak;
    logic [7:0]  shade;
    logic        painted;
    logic        ratio_error;
} plot_res_t;

class plot_scoreboard;
    bit [19:0]   cells [GRID*GRID];
    longint      px, py;
    bit [19:0]   peak;
    longint      ca, cb;
    int unsigned weight, iters;
    plot_res_t   pending_q[$];
    int unsigned painted_q[$];
    int          fails;
    longint      atan_tbl [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};

    function new();
        wipe();
        ca = -167772;
        cb = 83886;
        weight = 2;
        iters = 8000;
        fails = 0;
    endfunction

    function void wipe();
        foreach (cells[i]) cells[i] = '0;
        painted_q.delete();
        peak = '0;
        px = longint'(GRID) << 15;
        py = longint'(GRID) << 15;
    endfunction

    function void set_reg(logic [1:0] idx, longint val);
        case (idx)
            REG_COEF_A:     ca = longint'($signed(val[22:0]));
            REG_COEF_B:     cb = longint'($signed(val[22:0]));
            REG_HIT_WEIGHT: weight = val[7:0];
            REG_RUN_LENGTH: iters = val[15:0];
            default: ;
        endcase
    endfunction

    function void trig(longint ang, output longint sn, output longint cs);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = ang % 411775;
        flip = 0;
        if (r > 205887) r -= 411775;
        if (r < -205887) r += 411775;
        if (r > 102944) begin r = 205887 - r; flip = 1; end
        else if (r < -102944) begin r = -205887 - r; flip = 1; end
        x = 39797;
        y = 0;
        z = r;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_tbl[i]; end
            else begin x += dx; y -= dy; z += atan_tbl[i]; end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function longint angle(longint coef, longint pos);
        return (coef * pos + (longint'(1) << 22)) >>> 23;
    endfunction

    function longint map_coord(longint diff);
        longint v;
        v = ((diff * 13107 * GRID + 32768) >>> 16) + (longint'(GRID) << 15);
        if (v < 0) v = 0;
        if (v > (longint'(GRID) << 16) - 1) v = (longint'(GRID) << 16) - 1;
        return v;
    endfunction

    function int unsigned cell_of(longint pos);
        longint c;
        c = (pos + 32768) >>> 16;
        if (c > GRID - 1) c = GRID - 1;
        return 32'(c);
    endfunction

    function void step_map();
        longint s1, c1, s2, c2, s3, c3, s4, c4, nx, ny, sum;
        int unsigned idx;
        trig(angle(ca, py), s1, c1);
        trig(angle(cb, px), s2, c2);
        trig(angle(-ca, px), s3, c3);
        trig(angle(-cb, py), s4, c4);
        nx = map_coord(s1 - c2);
        ny = map_coord(s3 - c4);
        idx = cell_of(nx) * GRID + cell_of(ny);
        if (cells[idx] == 0) painted_q = {painted_q, idx};
        sum = longint'(cells[idx]) + weight;
        cells[idx] = (sum > 20'hFFFFF) ? 20'hFFFFF : sum[19:0];
        if (cells[idx] > peak) peak = cells[idx];
        px = nx;
        py = ny;
    endfunction

    function int unsigned log2_q8(int unsigned v);
        int unsigned e, f;
        bit [63:0] m;
        e = 0;
        f = 0;
        while (e < 31 && (v >> (e + 1)) != 0) e++;
        m = 64'(v) << (30 - e);
        for (int i = 8; i > 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                f |= 1 << (i - 1);
                m >>= 1;
            end
        end
        return (e << 8) | f;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] row, logic [7:0] col);
        plot_res_t r;
        int unsigned cnt, lp, lc;
        longint light, v;
        r = '0;
        if (op == OP_RUN)
        begin
            for (int unsigned i = 0; i < iters; i++) step_map();
        end
        else if (op == OP_READ)
        begin
            cnt = cells[row * GRID + col];
            if (cnt != 0)
            begin
                lp = log2_q8(peak == 0 ? 1 : peak);
                r.painted = 1;
                if (lp == 0) r.ratio_error = 1;
                else
                begin
                    lc = log2_q8(cnt);
                    light = (longint'(255) * lc + lp - 1) / lp;
                    v = light >= 300 ? 0 : 300 - light;
                    r.shade = v > 255 ? 8'd255 : v[7:0];
                end
            end
        end
        else if (op == OP_CLEAR) wipe();
        r.pos_x = px[23:0];
        r.pos_y = py[23:0];
        r.peak = peak;
        pending_q = {pending_q, r};
    endfunction

    function void check_result(plot_res_t got);
        plot_res_t exp_r;
        if (pending_q.size() == 0)
        begin
            fails++;
            if (fails <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got !== exp_r)
        begin
            fails++;
            if (fails <= 10)
                $display(
                    "exp x=%h y=%h pk=%h sh=%h p=%b e=%b got x=%h y=%h pk=%h sh=%h p=%b e=%b",
                    exp_r.pos_x, exp_r.pos_y, exp_r.peak, exp_r.shade, exp_r.painted,
                    exp_r.ratio_error, got.pos_x, got.pos_y, got.peak, got.shade,
                    got.painted, got.ratio_error);
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          send_idle, recv_idle;
    int          stall_cycles;

    cmdp_cmd_if cmd ();
    cmdp_res_if res ();

    plot_scoreboard sb = new();

    chaotic_map_density_plotter_unit DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cmd.valid = 0;
        cmd.opcode = '0;
        cmd.cell_row = '0;
        cmd.cell_col = '0;
        res.ready = 0;
        send_idle = 12;
        recv_idle = 78;
        repeat (6) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_idle);

    // result check; samples pre-edge values
    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
            sb.check_result({res.pos_x_out, res.pos_y_out, res.peak_out, res.shade,
                             res.painted, res.ratio_error});

    // watchdog: cycles without any request or result moving
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 400000)
        begin
            $display("chaotic_map_density_plotter_unit verification failed");
            $finish;
        end
    end
    initial stall_cycles = 0;

    task automatic reg_write(input logic [1:0] idx, input longint val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val[31:0];
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_req(input logic [1:0] op, input logic [7:0] row,
                            input logic [7:0] col);
        if ($urandom_range(99) < send_idle)
        begin
            cmd.valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        cmd.valid <= 1;
        cmd.opcode <= op;
        cmd.cell_row <= row;
        cmd.cell_col <= col;
        do @(posedge clk); while (!cmd.ready);
        sb.note_request(op, row, col);
    endtask

    task automatic read_painted();
        int unsigned idx;
        if (sb.painted_q.size() == 0) idx = $urandom_range(GRID*GRID - 1);
        else idx = sb.painted_q[$urandom_range(sb.painted_q.size() - 1)];
        send_req(OP_READ, idx[15:8], idx[7:0]);
    endtask

    task automatic drain();
        cmd.valid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int r;
        @(posedge rst_n);
        @(posedge clk);
        reg_write(REG_COEF_A, -167772);
        reg_write(REG_COEF_B, 83886);
        reg_write(REG_HIT_WEIGHT, 1);
        reg_write(REG_RUN_LENGTH, 1);

        // empty store, then peak of one gives the ratio error
        send_req(OP_READ, 8'd0, 8'd0);
        send_req(OP_RUN, 8'd0, 8'd0);
        read_painted();
        send_req(OP_READ, 8'd255, 8'd255);
        send_req(2'd3, 8'd255, 8'd0);
        send_req(OP_RUN, 8'd0, 8'd0);
        send_req(OP_RUN, 8'd0, 8'd0);
        read_painted();
        read_painted();
        drain();

        reg_write(REG_COEF_A, 4194303);
        reg_write(REG_COEF_B, -4194304);
        reg_write(REG_HIT_WEIGHT, 255);
        reg_write(REG_RUN_LENGTH, 2);
        send_req(OP_RUN, 8'd0, 8'd0);
        send_req(OP_RUN, 8'd0, 8'd0);
        read_painted();
        read_painted();
        send_req(OP_READ, 8'd0, 8'd255);
        drain();

        // longest run length is only held while reads and an unused opcode go through
        reg_write(REG_COEF_A, -4194304);
        reg_write(REG_COEF_B, 4194303);
        reg_write(REG_RUN_LENGTH, 65535);
        read_painted();
        read_painted();
        send_req(2'd3, 8'd0, 8'd0);
        drain();
        reg_write(REG_RUN_LENGTH, 1);
        send_req(OP_RUN, 8'd0, 8'd0);
        read_painted();
        send_req(OP_CLEAR, 8'd0, 8'd0);
        send_req(OP_READ, 8'd128, 8'd128);
        send_req(OP_RUN, 8'd0, 8'd0);
        read_painted();
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 12 : (ph == 1) ? 78 : 0;
            recv_idle = (ph == 0) ? 78 : (ph == 1) ? 12 : 0;
            reg_write(REG_COEF_A, longint'($signed(23'($urandom))));
            reg_write(REG_COEF_B, longint'($signed(23'($urandom))));
            reg_write(REG_HIT_WEIGHT, $urandom_range(255, 1));
            reg_write(REG_RUN_LENGTH, $urandom_range(6, 1));
            for (int n = 0; n < 250; n++)
            begin
                r = $urandom_range(99);
                if (ph == 1 && n == 125) send_req(OP_CLEAR, 8'($urandom), 8'($urandom));
                else if (r < 2) send_req(2'd3, 8'($urandom), 8'($urandom));
                else if (r < 30) send_req(OP_RUN, 8'($urandom), 8'($urandom));
                else if (r < 82) read_painted();
                else send_req(OP_READ, 8'($urandom), 8'($urandom));
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.fails == 0 && sb.pending_q.size() == 0)
            $display("chaotic_map_density_plotter_unit verification clean");
        else
            $display("chaotic_map_density_plotter_unit verification failed");
        $finish;
    end
endmodule
